>>> hw/rtl/cgr_pkg.sv
`default_nettype none
package cgr_pkg;

  localparam int MAX_STOPS     = 7;
  localparam int STOP_REGS     = 7;
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_W         = POS_FRAC_BITS + 1;
  localparam int IDX_W         = 3;
  localparam int CNT_W         = 3;
  localparam int CHAN_W        = 8;
  localparam int NCHAN         = 4;
  localparam int COLOR_W       = 32;
  localparam int STOP_W        = 49;
  localparam int POS_LSB       = 32;
  localparam int PROD_W        = CHAN_W + POS_W;
  localparam int NUM_W         = PROD_W + 1;
  localparam int DIV_STEPS     = CHAN_W;
  localparam int DATA_W        = 64;
  localparam int ADDR_W        = 6;
  localparam int REG_IDX_W     = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STOP0      = 3'd1;

  // channel order of the result
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  typedef logic [NCHAN-1:0][CHAN_W-1:0] rgba_t;

  typedef struct packed {
    logic [CNT_W-1:0]                   count;
    logic [STOP_REGS-1:0][STOP_W-1:0]   stops;
  } cfg_t;

  typedef struct packed {
    logic                          bypass;
    rgba_t                         color;
    logic [POS_W-1:0]              d;
    logic [NCHAN-1:0][NUM_W-1:0]   num;
  } work_t;

  function automatic logic [POS_W-1:0] stop_pos(input logic [STOP_W-1:0] s);
    stop_pos = s[POS_LSB +: POS_W];
  endfunction

  // argb word split into result channel order
  function automatic rgba_t split_color(input logic [STOP_W-1:0] s);
    rgba_t c;
    c[CH_RED]   = s[23:16];
    c[CH_GREEN] = s[15:8];
    c[CH_BLUE]  = s[7:0];
    c[CH_ALPHA] = s[31:24];
    split_color = c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cgr_regs.sv
`default_nettype none
module cgr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cgr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cgr_pkg::DATA_W-1:0] pwdata,
  output logic      [cgr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output cgr_pkg::cfg_t                   cfg
);
  import cgr_pkg::*;

  logic [CNT_W-1:0]                 count_r;
  logic [STOP_REGS-1:0][STOP_W-1:0] stops_r;
  logic [REG_IDX_W-1:0]             idx;
  logic                             wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign wr     = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
      stops_r <= '0;
    end else if (wr) begin
      if (idx == REG_STOP_COUNT) begin
        count_r <= pwdata[CNT_W-1:0];
      end else begin
        stops_r[idx - REG_STOP0] <= pwdata[STOP_W-1:0];
      end
    end
  end

  // read back
  always_comb begin
    if (idx == REG_STOP_COUNT) begin
      prdata = DATA_W'(count_r);
    end else begin
      prdata = DATA_W'(stops_r[idx - REG_STOP0]);
    end
  end

  assign cfg.count = count_r;
  assign cfg.stops = stops_r;

endmodule
`default_nettype wire

>>> hw/rtl/cgr_front.sv
`default_nettype none
module cgr_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [cgr_pkg::POS_W-1:0] in_pos,
  input  wire cgr_pkg::cfg_t             cfg,
  output logic                           out_valid,
  output cgr_pkg::work_t                 out_work
);
  import cgr_pkg::*;

  // stage 1: locate
  logic             v1_r, byp1_r;
  logic [POS_W-1:0] pos1_r;
  logic [IDX_W-1:0] idx1_r;
  logic [CNT_W-1:0] n;
  logic             found, byp1_nxt;
  logic [IDX_W-1:0] hit, idx1_nxt;

  // stage 2: select and subtract
  logic                         v2_r, byp2_r;
  rgba_t                        col2_r, c0_2_r, c1_2_r;
  logic [POS_W-1:0]             a2_r, b2_r, d2_r;
  logic [IDX_W-1:0]             pre;
  logic [POS_W-1:0]             p0, p1;

  // stage 3: products
  logic                         v3_r, byp3_r;
  rgba_t                        col3_r;
  logic [POS_W-1:0]             d3_r;
  logic [NCHAN-1:0][PROD_W-1:0] m0_3_r, m1_3_r;

  // stage 4: sums
  logic                         v4_r, byp4_r;
  rgba_t                        col4_r;
  logic [POS_W-1:0]             d4_r;
  logic [NCHAN-1:0][NUM_W-1:0]  num4_r;

  // first stop above the position
  always_comb begin
    if (cfg.count == '0) begin
      n = CNT_W'(1);
    end else if (cfg.count > CNT_W'(MAX_STOPS)) begin
      n = CNT_W'(MAX_STOPS);
    end else begin
      n = cfg.count;
    end
    found = 1'b0;
    hit   = '0;
    for (int i = MAX_STOPS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < n) && (in_pos < stop_pos(cfg.stops[i]))) begin
        found = 1'b1;
        hit   = IDX_W'(i);
      end
    end
    priority if (in_pos == '0 || (found && hit == '0)) begin
      byp1_nxt = 1'b1;
      idx1_nxt = '0;
    end else if (!found) begin
      byp1_nxt = 1'b1;
      idx1_nxt = IDX_W'(n - CNT_W'(1));
    end else begin
      byp1_nxt = 1'b0;
      idx1_nxt = hit;
    end
  end

  always_comb begin
    pre = byp1_r ? '0 : idx1_r - IDX_W'(1);
    p0  = stop_pos(cfg.stops[pre]);
    p1  = stop_pos(cfg.stops[idx1_r]);
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r <= in_pos;
      byp1_r <= byp1_nxt;
      idx1_r <= idx1_nxt;

      byp2_r <= byp1_r;
      col2_r <= split_color(cfg.stops[idx1_r]);
      c0_2_r <= split_color(cfg.stops[pre]);
      c1_2_r <= split_color(cfg.stops[idx1_r]);
      a2_r   <= p1 - pos1_r;
      b2_r   <= pos1_r - p0;
      d2_r   <= p1 - p0;

      byp3_r <= byp2_r;
      col3_r <= col2_r;
      d3_r   <= d2_r;
      for (int k = 0; k < NCHAN; k++) begin
        m0_3_r[k] <= PROD_W'(c0_2_r[k]) * PROD_W'(a2_r);
        m1_3_r[k] <= PROD_W'(c1_2_r[k]) * PROD_W'(b2_r);
      end

      byp4_r <= byp3_r;
      col4_r <= col3_r;
      d4_r   <= d3_r;
      for (int k = 0; k < NCHAN; k++) begin
        num4_r[k] <= NUM_W'(m0_3_r[k]) + NUM_W'(m1_3_r[k]);
      end
    end
  end

  assign out_valid       = v4_r;
  assign out_work.bypass = byp4_r;
  assign out_work.color  = col4_r;
  assign out_work.d      = d4_r;
  assign out_work.num    = num4_r;

endmodule
`default_nettype wire

>>> hw/rtl/cgr_div.sv
`default_nettype none
module cgr_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire cgr_pkg::work_t in_work,
  output logic                out_valid,
  output cgr_pkg::rgba_t      out_color
);
  import cgr_pkg::*;

  logic [DIV_STEPS-1:0]                          v_r, byp_r;
  logic [DIV_STEPS-1:0][NCHAN-1:0][NUM_W-1:0]    rem_r, rem_nxt;
  logic [DIV_STEPS-1:0][NCHAN-1:0][CHAN_W-1:0]   q_r, q_nxt;
  logic [DIV_STEPS-1:0][POS_W-1:0]               d_r, d_in;
  logic [DIV_STEPS-1:0][NCHAN-1:0][CHAN_W-1:0]   col_r, col_in;
  logic [DIV_STEPS-1:0]                          byp_in;

  // one quotient bit per stage, msb first
  always_comb begin
    logic [NUM_W-1:0]  r, sh;
    logic [CHAN_W-1:0] qi;
    for (int j = 0; j < DIV_STEPS; j++) begin
      d_in[j]   = (j == 0) ? in_work.d      : d_r[j-1];
      col_in[j] = (j == 0) ? in_work.color  : col_r[j-1];
      byp_in[j] = (j == 0) ? in_work.bypass : byp_r[j-1];
      for (int k = 0; k < NCHAN; k++) begin
        r  = (j == 0) ? in_work.num[k] : rem_r[j-1][k];
        qi = (j == 0) ? '0 : q_r[j-1][k];
        sh = NUM_W'(d_in[j]) << (DIV_STEPS - 1 - j);
        if (r >= sh) begin
          rem_nxt[j][k] = r - sh;
          q_nxt[j][k]   = qi | (CHAN_W'(1) << (DIV_STEPS - 1 - j));
        end else begin
          rem_nxt[j][k] = r;
          q_nxt[j][k]   = qi;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      d_r   <= d_in;
      col_r <= col_in;
      byp_r <= byp_in;
    end
  end

  // stop color or quotient
  assign out_valid = v_r[DIV_STEPS-1];
  assign out_color = byp_r[DIV_STEPS-1] ? col_r[DIV_STEPS-1] : q_r[DIV_STEPS-1];

endmodule
`default_nettype wire

>>> hw/rtl/color_gradient_ramp.sv
`default_nettype none
// channel    ports                           transfer when
// input      in_valid in_ready in_position  in_valid & in_ready
// result     out_valid out_ready out_*       out_valid & out_ready
// config     psel penable pwrite paddr ...   psel & penable & pwrite
//
// twelve register stages: locate, select, multiply, add, eight divide steps
// one position accepted per cycle unless a held result stalls the pipe
// the divider resolves one quotient bit per stage
// rst_n synchronous, clears valid bits and sets stop count to one
// a stall on out_ready holds every stage in place
module color_gradient_ramp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cgr_pkg::POS_W-1:0]   in_position,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [cgr_pkg::CHAN_W-1:0]  out_red,
  output logic      [cgr_pkg::CHAN_W-1:0]  out_green,
  output logic      [cgr_pkg::CHAN_W-1:0]  out_blue,
  output logic      [cgr_pkg::CHAN_W-1:0]  out_alpha,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cgr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cgr_pkg::DATA_W-1:0]  pwdata,
  output logic      [cgr_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import cgr_pkg::*;

  cfg_t  cfg;
  work_t work;
  logic  work_valid, en;
  rgba_t color;

  // whole pipe advances unless the result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  cgr_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cgr_front u_front (
    .clk, .rst_n, .en, .in_valid, .in_pos(in_position), .cfg,
    .out_valid(work_valid), .out_work(work)
  );

  cgr_div u_div (
    .clk, .rst_n, .en, .in_valid(work_valid), .in_work(work),
    .out_valid, .out_color(color)
  );

  assign out_red   = color[CH_RED];
  assign out_green = color[CH_GREEN];
  assign out_blue  = color[CH_BLUE];
  assign out_alpha = color[CH_ALPHA];

endmodule
`default_nettype wire

>>> hw/rtl/cgr_checker.sv
`default_nettype none
module cgr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [cgr_pkg::CHAN_W-1:0]  out_red,
  input wire logic [cgr_pkg::CHAN_W-1:0]  out_green,
  input wire logic [cgr_pkg::CHAN_W-1:0]  out_blue,
  input wire logic [cgr_pkg::CHAN_W-1:0]  out_alpha,
  input wire logic                        pready
);

  // held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha))
    else $error("result changed while stalled");

  // a held result stalls the input
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // empty output never blocks input
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind color_gradient_ramp cgr_checker u_cgr_checker (.*);
`default_nettype wire
